// ===== rtl/swmf_pkg.sv =====
`timescale 1ns / 1ps

package swmf_pkg;

  // Sample and median width
  localparam int SAMPLE_W = 32;

  // Window length register
  localparam int WLEN_W = 5;
  localparam logic [WLEN_W-1:0] WLEN_RESET = 5'd5;

  // Default depth of the sample window
  localparam int DEFAULT_MAX_WINDOW = 16;

  // Input action codes
  localparam logic ACT_PUSH  = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

endpackage

// ===== rtl/swmf_in_if.sv =====
`timescale 1ns / 1ps

interface swmf_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  action;
  logic signed [swmf_pkg::SAMPLE_W-1:0]  sample;

  modport source (output valid, output action, output sample, input ready);
  modport sink   (input valid, input action, input sample, output ready);
endinterface

// ===== rtl/swmf_out_if.sv =====
`timescale 1ns / 1ps

interface swmf_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [swmf_pkg::SAMPLE_W-1:0]  median;

  modport source (output valid, output median, input ready);
  modport sink   (input valid, input median, output ready);
endinterface

// ===== rtl/sliding_window_median_filter_core.sv =====
`timescale 1ns / 1ps

// Running median filter. Each push transfer stores a signed 32-bit sample in a
// window of the last window_length samples (1..MAX_WINDOW; 0 acts as 1, larger
// values act as MAX_WINDOW) and returns the sample at rank floor(c/2), c being
// the number of samples held before the push; the first sample after a clear
// comes back unchanged. A clear transfer empties the window and returns
// nothing; a write to window_length, taken only while idle, empties it too.
// The window is kept as a rank-ordered list of {slot, value} words in one
// single-port-read RAM, and one compare unit walks that list one word per
// cycle: a full window first scans for the oldest slot, then the new sample
// is moved up or down one neighbor per cycle and written in place. The block
// takes no input while a push is in work, but the next push may start while
// the last median waits in the output register.
module sliding_window_median_filter_core #(
  parameter int MAX_WINDOW = swmf_pkg::DEFAULT_MAX_WINDOW
) (
  input  logic                        clk,
  input  logic                        rst_n,
  swmf_in_if.sink                     in_chan,
  swmf_out_if.source                  out_chan,
  input  logic                        cfg_we,
  input  logic [swmf_pkg::WLEN_W-1:0] cfg_wdata
);

  localparam int SW     = swmf_pkg::SAMPLE_W;
  localparam int IDX_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int WL_W   = swmf_pkg::WLEN_W;
  localparam int EXT_W  = (CNT_W > WL_W) ? CNT_W : WL_W;
  localparam int WORD_W = IDX_W + SW;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_START  = 3'd1;
  localparam logic [2:0] ST_SEARCH = 3'd2;
  localparam logic [2:0] ST_MOVE   = 3'd3;
  localparam logic [2:0] ST_PLACE  = 3'd4;
  localparam logic [2:0] ST_MED    = 3'd5;
  localparam logic [2:0] ST_DONE   = 3'd6;

  logic [2:0]            st_r, st_nxt;
  logic [WL_W-1:0]       wlen_r, wlen_nxt;
  logic [IDX_W-1:0]      write_slot_r, write_slot_nxt;
  logic [CNT_W-1:0]      fill_count_r, fill_count_nxt;
  logic signed [SW-1:0]  v_r, v_nxt;
  logic [IDX_W-1:0]      pos_r, pos_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [IDX_W-1:0]      o_r, o_nxt;
  logic [IDX_W-1:0]      k_r, k_nxt;
  logic                  dir_up_r, dir_up_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic signed [SW-1:0]  out_median_r, out_median_nxt;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [WORD_W-1:0]     ram_wdata;
  logic                  ram_re;
  logic [IDX_W-1:0]      ram_raddr;
  logic [WORD_W-1:0]     ram_rdata;

  logic [CNT_W-1:0]      len_c;
  logic [EXT_W-1:0]      wlen_ext;
  logic [IDX_W-1:0]      rd_slot;
  logic signed [SW-1:0]  rd_val;
  logic                  in_xfer;

  // Effective window length
  assign wlen_ext = EXT_W'(wlen_r);
  always_comb begin
    if (wlen_r == '0) begin
      len_c = CNT_W'(1);
    end else if (wlen_ext > EXT_W'(MAX_WINDOW)) begin
      len_c = CNT_W'(MAX_WINDOW);
    end else begin
      len_c = CNT_W'(wlen_ext);
    end
  end

  assign rd_slot = ram_rdata[SW +: IDX_W];
  assign rd_val  = signed'(ram_rdata[SW-1:0]);
  assign in_xfer = in_chan.valid && in_chan.ready;

  assign in_chan.ready   = (st_r == ST_IDLE);
  assign out_chan.valid  = out_valid_r;
  assign out_chan.median = out_median_r;

  // Rank list: {slot, value} words in ascending value order
  swmf_ram #(
    .DATA_W (WORD_W),
    .DEPTH  (MAX_WINDOW)
  ) u_rank_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer
  always_comb begin
    logic [CNT_W-1:0] cnt_c;
    logic [IDX_W-1:0] pos_c;
    logic [CNT_W-1:0] pos_inc;
    logic [IDX_W-1:0] nb;
    logic             move_on;
    logic             has_next;
    logic             go_up;
    logic             go_down;

    st_nxt         = st_r;
    wlen_nxt       = wlen_r;
    write_slot_nxt = write_slot_r;
    fill_count_nxt = fill_count_r;
    v_nxt          = v_r;
    pos_nxt        = pos_r;
    cnt_nxt        = cnt_r;
    o_nxt          = o_r;
    k_nxt          = k_r;
    dir_up_nxt     = dir_up_r;
    out_valid_nxt  = out_valid_r;
    out_median_nxt = out_median_r;

    ram_we    = 1'b0;
    ram_waddr = o_r;
    ram_wdata = {pos_r, v_r};
    ram_re    = 1'b0;
    ram_raddr = '0;

    cnt_c    = (fill_count_r > len_c) ? len_c : fill_count_r;
    pos_c    = (CNT_W'(write_slot_r) >= len_c) ? '0 : write_slot_r;
    pos_inc  = '0;
    nb       = dir_up_r ? (o_r + IDX_W'(1)) : (o_r - IDX_W'(1));
    move_on  = dir_up_r ? (rd_val < v_r) : (rd_val > v_r);
    has_next = dir_up_r ? ((CNT_W'(nb) + CNT_W'(1)) < cnt_r) : (nb != '0);
    go_up    = rd_val < v_r;
    go_down  = rd_val > v_r;

    // Drop the result once the sink takes it
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (st_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_chan.action == swmf_pkg::ACT_CLEAR) begin
            write_slot_nxt = '0;
            fill_count_nxt = '0;
          end else begin
            v_nxt  = in_chan.sample;
            st_nxt = ST_START;
          end
        end
        if (cfg_we) begin
          wlen_nxt       = cfg_wdata;
          write_slot_nxt = '0;
          fill_count_nxt = '0;
        end
      end

      ST_START: begin
        cnt_nxt = cnt_c;
        if (cnt_c == '0) begin
          // Empty window: slot 0 holds the sample alone
          pos_c     = '0;
          ram_we    = 1'b1;
          ram_waddr = '0;
          ram_wdata = {IDX_W'(0), v_r};
          st_nxt    = ST_MED;
        end else if (cnt_c < len_c) begin
          // Filling: join at the top, then move down
          o_nxt      = pos_c;
          dir_up_nxt = 1'b0;
          if (pos_c != '0) begin
            ram_re    = 1'b1;
            ram_raddr = pos_c - IDX_W'(1);
            st_nxt    = ST_MOVE;
          end else begin
            st_nxt = ST_PLACE;
          end
        end else begin
          // Full: scan for the oldest slot
          ram_re    = 1'b1;
          ram_raddr = '0;
          k_nxt     = '0;
          st_nxt    = ST_SEARCH;
        end
        pos_nxt        = pos_c;
        pos_inc        = CNT_W'(pos_c) + CNT_W'(1);
        write_slot_nxt = (pos_inc >= len_c) ? '0 : IDX_W'(pos_inc);
        if (cnt_c < len_c) begin
          fill_count_nxt = cnt_c + CNT_W'(1);
        end
      end

      ST_SEARCH: begin
        if (rd_slot == pos_r) begin
          o_nxt = k_r;
          if (go_up && ((CNT_W'(k_r) + CNT_W'(1)) < cnt_r)) begin
            ram_re     = 1'b1;
            ram_raddr  = k_r + IDX_W'(1);
            dir_up_nxt = 1'b1;
            st_nxt     = ST_MOVE;
          end else if (go_down && (k_r != '0)) begin
            ram_re     = 1'b1;
            ram_raddr  = k_r - IDX_W'(1);
            dir_up_nxt = 1'b0;
            st_nxt     = ST_MOVE;
          end else begin
            st_nxt = ST_PLACE;
          end
        end else if ((CNT_W'(k_r) + CNT_W'(1)) < cnt_r) begin
          ram_re    = 1'b1;
          ram_raddr = k_r + IDX_W'(1);
          k_nxt     = k_r + IDX_W'(1);
        end else begin
          o_nxt  = '0;
          st_nxt = ST_PLACE;
        end
      end

      ST_MOVE: begin
        ram_we    = 1'b1;
        ram_waddr = o_r;
        if (move_on) begin
          // Shift the neighbor into the hole and advance
          ram_wdata = ram_rdata;
          o_nxt     = nb;
          if (has_next) begin
            ram_re    = 1'b1;
            ram_raddr = dir_up_r ? (nb + IDX_W'(1)) : (nb - IDX_W'(1));
          end else begin
            st_nxt = ST_PLACE;
          end
        end else begin
          ram_wdata = {pos_r, v_r};
          st_nxt    = ST_MED;
        end
      end

      ST_PLACE: begin
        ram_we    = 1'b1;
        ram_waddr = o_r;
        ram_wdata = {pos_r, v_r};
        st_nxt    = ST_MED;
      end

      ST_MED: begin
        ram_re    = 1'b1;
        ram_raddr = IDX_W'(cnt_r >> 1);
        st_nxt    = ST_DONE;
      end

      ST_DONE: begin
        // Hold the read word until the output register is free
        if (!out_valid_r || out_chan.ready) begin
          out_median_nxt = rd_val;
          out_valid_nxt  = 1'b1;
          st_nxt         = ST_IDLE;
        end
      end

      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_IDLE;
      wlen_r       <= swmf_pkg::WLEN_RESET;
      write_slot_r <= '0;
      fill_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      st_r         <= st_nxt;
      wlen_r       <= wlen_nxt;
      write_slot_r <= write_slot_nxt;
      fill_count_r <= fill_count_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Work and payload registers
  always_ff @(posedge clk) begin
    v_r          <= v_nxt;
    pos_r        <= pos_nxt;
    cnt_r        <= cnt_nxt;
    o_r          <= o_nxt;
    k_r          <= k_nxt;
    dir_up_r     <= dir_up_nxt;
    out_median_r <= out_median_nxt;
  end

`ifndef SYNTHESIS
  a_fill_le_len: assert property (@(posedge clk) disable iff (!rst_n)
    fill_count_r <= len_c)
    else $error("fill count exceeds window length");

  a_slot_tracks_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_IDLE && fill_count_r < len_c) |-> CNT_W'(write_slot_r) == fill_count_r)
    else $error("write slot out of step with fill count while filling");

  a_push_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_chan.action == swmf_pkg::ACT_PUSH) |=> st_r == ST_START)
    else $error("push transfer did not start the sequencer");

  a_move_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_MOVE) |-> CNT_W'(o_r) <= cnt_r)
    else $error("rank position out of range during move");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(st_r) == ST_DONE)
    else $error("result raised outside the done state");
`endif

endmodule

// ===== rtl/swmf_ram.sv =====
`timescale 1ns / 1ps

module swmf_ram #(
  parameter int  DATA_W = 8,
  parameter int  DEPTH  = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write one word, read one word; read data holds while re is low
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== bench/sliding_window_median_filter_core_test.sv =====
`timescale 1ns / 1ps

module sliding_window_median_filter_core_test;

  localparam int SW          = swmf_pkg::SAMPLE_W;
  localparam int LW          = swmf_pkg::WLEN_W;
  localparam int WIN_DEPTH   = swmf_pkg::DEFAULT_MAX_WINDOW;
  localparam int SETTLE      = 2 * WIN_DEPTH + 8;
  localparam int PHASE_ITEMS = 140;
  localparam int NUM_PHASES  = 10;
  localparam int LONG_HOLD   = 400;
  localparam int CYCLE_LIMIT = 600000;
  localparam logic signed [SW-1:0] S_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [SW-1:0] S_MIN = 32'sh8000_0000;

  // One offered item; pinned rows carry a median typed in by hand
  typedef struct packed {
    logic                 action;
    logic signed [SW-1:0] sample;
    logic                 pinned;
    logic signed [SW-1:0] want;
  } stim_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [LW-1:0] cfg_wdata;

  swmf_in_if  in_chan ();
  swmf_out_if out_chan ();

  sliding_window_median_filter_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Window mirror kept in step with accepted transfers
  logic signed [SW-1:0] win_samples [WIN_DEPTH];
  logic [3:0]           win_rank [WIN_DEPTH];
  logic [3:0]           next_slot;
  logic [4:0]           held_count;
  logic [LW-1:0]        win_len_reg;

  logic signed [SW-1:0] pending_medians [$];
  stim_t offered;
  int    n_taken;
  int    errors;
  int    cycle_count;
  bit    calm;

  // Directed part: reset length 5, extremes, overwrite moving up and down, ties, clears
  localparam int PLAN_LEN = 23;
  stim_t plan [PLAN_LEN] = '{
    '{swmf_pkg::ACT_PUSH,  S_MAX,          1'b1, S_MAX},
    '{swmf_pkg::ACT_PUSH,  S_MIN,          1'b0, 32'sd0},
    '{swmf_pkg::ACT_PUSH,  32'sd0,         1'b0, 32'sd0},
    '{swmf_pkg::ACT_PUSH,  -32'sd1,        1'b0, 32'sd0},
    '{swmf_pkg::ACT_PUSH,  32'sd1,         1'b0, 32'sd0},
    '{swmf_pkg::ACT_PUSH,  32'sd100,       1'b0, 32'sd0},
    '{swmf_pkg::ACT_PUSH,  S_MAX,          1'b0, 32'sd0},
    '{swmf_pkg::ACT_PUSH,  32'sd7,         1'b0, 32'sd0},
    '{swmf_pkg::ACT_PUSH,  32'sd7,         1'b0, 32'sd0},
    '{swmf_pkg::ACT_PUSH,  32'sd7,         1'b0, 32'sd0},
    '{swmf_pkg::ACT_PUSH,  32'sd7,         1'b0, 32'sd0},
    '{swmf_pkg::ACT_CLEAR, 32'sh1234_5678, 1'b0, 32'sd0},
    '{swmf_pkg::ACT_PUSH,  -32'sd7,        1'b1, -32'sd7},
    '{swmf_pkg::ACT_PUSH,  -32'sd7,        1'b0, 32'sd0},
    '{swmf_pkg::ACT_CLEAR, S_MAX,          1'b0, 32'sd0},
    '{swmf_pkg::ACT_CLEAR, S_MIN,          1'b0, 32'sd0},
    '{swmf_pkg::ACT_PUSH,  32'sd0,         1'b1, 32'sd0},
    '{swmf_pkg::ACT_PUSH,  32'sh5555_5555, 1'b0, 32'sd0},
    '{swmf_pkg::ACT_PUSH,  32'shAAAA_AAAA, 1'b0, 32'sd0},
    '{swmf_pkg::ACT_PUSH,  S_MIN,          1'b0, 32'sd0},
    '{swmf_pkg::ACT_PUSH,  S_MIN,          1'b0, 32'sd0},
    '{swmf_pkg::ACT_PUSH,  S_MAX,          1'b0, 32'sd0},
    '{swmf_pkg::ACT_PUSH,  -32'sd2,        1'b0, 32'sd0}
  };

  logic [LW-1:0] phase_lengths [NUM_PHASES] = '{
    5'd1, 5'd16, 5'd0, 5'd31, 5'd17, 5'd3, 5'd2, 5'd5, 5'd8, 5'd16
  };

  always #1 clk = ~clk;

  // Insert a sample into the mirror and return the median at rank floor(c/2)
  function automatic logic signed [SW-1:0] push_median(
    input logic signed [SW-1:0] smp);
    int len, cnt, pos, o, c;
    bit up, dn, moving;
    logic signed [SW-1:0] old, res;
    len = win_len_reg;
    if (len < 1) len = 1;
    if (len > WIN_DEPTH) len = WIN_DEPTH;
    cnt = held_count;
    pos = next_slot;
    if (cnt > len) cnt = len;
    if (pos >= len) pos = 0;
    if (cnt == 0) begin
      pos = 0;
      win_samples[0] = smp;
      win_rank[0] = 4'd0;
      res = smp;
    end else begin
      o = 0;
      up = 1'b0;
      dn = 1'b0;
      if (cnt >= len) begin
        // find the oldest slot in the rank list
        while (o < cnt && win_rank[o] != pos) o++;
        if (o >= cnt) o = 0;
        old = win_samples[pos];
        up = old < smp;
        dn = old > smp;
      end else begin
        win_rank[pos] = 4'(pos);
        o = pos;
        dn = 1'b1;
      end
      win_samples[pos] = smp;
      moving = 1'b1;
      if (up) begin
        while (moving && o + 1 < cnt) begin
          c = win_rank[o + 1];
          if (win_samples[c] < smp) begin
            win_rank[o + 1] = win_rank[o];
            win_rank[o] = 4'(c);
            o++;
          end else begin
            moving = 1'b0;
          end
        end
      end else if (dn) begin
        while (moving && o > 0) begin
          c = win_rank[o - 1];
          if (win_samples[c] > smp) begin
            win_rank[o - 1] = win_rank[o];
            win_rank[o] = 4'(c);
            o--;
          end else begin
            moving = 1'b0;
          end
        end
      end
      res = win_samples[win_rank[cnt / 2]];
    end
    pos++;
    next_slot = 4'((pos >= len) ? 0 : pos);
    if (cnt < len) held_count = 5'(cnt + 1);
    return res;
  endfunction

  // Mix of extremes, near ties and full-range values
  function automatic logic signed [SW-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return S_MAX;
      1: return S_MIN;
      2, 3, 4: return $signed($urandom_range(0, 8)) - 32'sd4;
      default: return $urandom;
    endcase
  endfunction

  function automatic stim_t random_item();
    stim_t it;
    it.action = ($urandom_range(0, 24) == 0) ? swmf_pkg::ACT_CLEAR : swmf_pkg::ACT_PUSH;
    it.sample = pick_sample();
    it.pinned = 1'b0;
    it.want = '0;
    return it;
  endfunction

  // Offer one item, optionally after an idle burst, and hold it until transfer
  task automatic send_item(input stim_t it);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_chan.valid  <= 1'b1;
    in_chan.action <= it.action;
    in_chan.sample <= it.sample;
    offered        <= it;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop offering, drain every outstanding median, then let the block go idle
  task automatic settle();
    in_chan.valid <= 1'b0;
    while (pending_medians.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_window_length(input logic [LW-1:0] len);
    cfg_we    <= 1'b1;
    cfg_wdata <= len;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  // Score result transfers and track accepted input and register writes
  always @(posedge clk) begin : track
    logic signed [SW-1:0] want;
    logic signed [SW-1:0] got;
    if (!rst_n) begin
      foreach (win_samples[i]) win_samples[i] = '0;
      foreach (win_rank[i]) win_rank[i] = '0;
      next_slot   = '0;
      held_count  = '0;
      win_len_reg = swmf_pkg::WLEN_RESET;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (pending_medians.size() == 0) begin
          errors++;
          $display("%0t: unexpected median, expected none, actual %0d",
                   $time, out_chan.median);
        end else begin
          want = pending_medians.pop_front();
          if (out_chan.median !== want) begin
            errors++;
            $display("%0t: median mismatch, expected %0d, actual %0d",
                     $time, want, out_chan.median);
          end
        end
      end
      if (cfg_we) begin
        win_len_reg = cfg_wdata;
        next_slot   = '0;
        held_count  = '0;
      end
      if (in_chan.valid && in_chan.ready) begin
        n_taken++;
        if (in_chan.action == swmf_pkg::ACT_CLEAR) begin
          next_slot  = '0;
          held_count = '0;
        end else begin
          got = push_median(in_chan.sample);
          pending_medians.push_back(offered.pinned ? offered.want : got);
        end
      end
    end
  end

  // Receiver: random stall bursts, plus two long hold-offs to back up the block
  initial begin : receiver
    int stall_left;
    int hold_left;
    int holds_done;
    stall_left = 0;
    hold_left  = 0;
    holds_done = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_done < 2 && n_taken >= 250 + holds_done * 550) begin
        hold_left = LONG_HOLD;
        holds_done++;
      end
      if (hold_left > 0) begin
        out_chan.ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_chan.ready <= 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_chan.ready <= 1'b0;
        stall_left = $urandom_range(1, 15) - 1;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    int ph;
    int k;
    logic [LW-1:0] len;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    in_chan.valid  = 1'b0;
    in_chan.action = swmf_pkg::ACT_PUSH;
    in_chan.sample = '0;
    offered        = '0;
    calm           = 1'b0;

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (k = 0; k < PLAN_LEN; k++) send_item(plan[k]);

    // Each phase drains, rewrites the length and runs random traffic
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      len = (ph == 7) ? LW'($urandom_range(0, 31)) : phase_lengths[ph];
      write_window_length(len);
      if (ph == NUM_PHASES - 1) calm = 1'b1;
      for (k = 0; k < PHASE_ITEMS; k++) send_item(random_item());
    end
    settle();

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
